// ===== sv/spd_pkg.sv =====
// Package for the serial packet deframer: phase and status types, CRC constants
// and the bytewise CRC-16 update function.
// No dependencies.
package spd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_ONGOING  = 2'd0,
        ST_GOOD     = 2'd1,
        ST_CRC_BAD  = 2'd2,
        ST_OVERSIZE = 2'd3
    } t_status;

    localparam logic [0:0]  CFG_START_BYTE = 1'd0;
    localparam logic [0:0]  CFG_MAX_FRAME  = 1'd1;

    localparam logic [7:0]  START_BYTE_RST = 8'd36;
    localparam logic [8:0]  MAX_FRAME_RST  = 9'd260;
    localparam logic [8:0]  HDR_BYTES      = 9'd5;

    localparam logic [8:0]  CNT_CRC_LO     = 9'd1;
    localparam logic [8:0]  CNT_CRC_HI     = 9'd2;
    localparam logic [8:0]  CNT_TYPE       = 9'd3;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL  = 16'h8408;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/spd_rx_if.sv =====
// Receive byte channel: valid/ready handshake with one received byte.
// No dependencies.
interface spd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/spd_res_if.sv =====
// Result channel: valid/ready handshake with one deframed result.
// No dependencies.
interface spd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] packet_type;
    logic       is_last;
    logic       has_byte;
    logic [1:0] frame_status;

    modport source (output valid, output payload_byte, output packet_type,
                    output is_last, output has_byte, output frame_status, input ready);
    modport sink   (input valid, input payload_byte, input packet_type,
                    input is_last, input has_byte, input frame_status, output ready);
endinterface

// ===== sv/serial_packet_deframer_crc16_core.sv =====
// Serial packet deframer with CRC-16 (X.25) check, top level.
// A result is registered and valid in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle unless a waiting result is not taken; the bytewise CRC update sets the cycle path.
// A new byte is taken while a result waits, as long as the result register frees.
// Reset (synchronous, i_rst_n low): hunting, start byte 36, frame limit 260.
// Depends on spd_pkg, spd_rx_if, spd_res_if.
module serial_packet_deframer_crc16_core
    import spd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    spd_rx_if.sink     i_rx,
    spd_res_if.source  o_res
);

    logic [7:0]  r_start_byte;
    logic [8:0]  r_max_frame;

    t_phase      r_phase, n_phase;
    logic [8:0]  r_count, n_count;
    logic [8:0]  r_target, n_target;
    logic [15:0] r_rcrc, n_rcrc;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_type, n_type;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_type;
    logic        r_out_last;
    logic        r_out_has;
    logic [1:0]  r_out_status;

    logic        n_res;
    logic [7:0]  n_res_byte;
    logic        n_res_last;
    logic        n_res_has;
    t_status     n_res_status;

    logic        w_ready;
    logic        w_fire;
    logic [7:0]  w_byte;
    logic [15:0] w_crc_fed;
    logic [8:0]  w_count_inc;
    t_status     w_final;

    assign w_ready     = !r_out_valid || o_res.ready;
    assign w_fire      = i_rx.valid && w_ready;
    assign w_byte      = i_rx.rx_byte;
    assign w_crc_fed   = crc_feed(r_crc, w_byte);
    assign w_count_inc = r_count + 9'd1;
    assign w_final     = ((w_crc_fed ^ CRC_XOROUT) == r_rcrc) ? ST_GOOD : ST_CRC_BAD;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HEADER: begin
                if (r_count != CNT_CRC_LO && r_count != CNT_CRC_HI && r_count != CNT_TYPE) begin
                    n_phase = (w_byte == 8'd0) ? PH_HUNT : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_count >= r_max_frame || w_count_inc == r_target) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = (w_byte == r_start_byte) ? PH_HEADER : PH_HUNT;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_count      = r_count;
        n_target     = r_target;
        n_rcrc       = r_rcrc;
        n_crc        = r_crc;
        n_type       = r_type;
        n_res        = 1'b0;
        n_res_byte   = 8'd0;
        n_res_last   = 1'b0;
        n_res_has    = 1'b0;
        n_res_status = ST_ONGOING;
        case (r_phase)
            PH_HEADER: begin
                case (r_count)
                    CNT_CRC_LO: begin
                        n_rcrc  = {8'h00, w_byte};
                        n_count = w_count_inc;
                    end
                    CNT_CRC_HI: begin
                        n_rcrc  = {w_byte, r_rcrc[7:0]};
                        n_count = w_count_inc;
                    end
                    CNT_TYPE: begin
                        n_type  = w_byte;
                        n_crc   = w_crc_fed;
                        n_count = w_count_inc;
                    end
                    default: begin
                        n_crc    = w_crc_fed;
                        n_count  = HDR_BYTES;
                        n_target = HDR_BYTES + {1'b0, w_byte};
                        if (w_byte == 8'd0) begin
                            n_res        = 1'b1;
                            n_res_last   = 1'b1;
                            n_res_status = w_final;
                        end
                    end
                endcase
            end
            PH_PAYLOAD: begin
                n_res = 1'b1;
                if (r_count >= r_max_frame) begin
                    n_res_last   = 1'b1;
                    n_res_status = ST_OVERSIZE;
                end else begin
                    n_count    = w_count_inc;
                    n_crc      = w_crc_fed;
                    n_res_byte = w_byte;
                    n_res_has  = 1'b1;
                    if (w_count_inc == r_target) begin
                        n_res_last   = 1'b1;
                        n_res_status = w_final;
                    end
                end
            end
            default: begin
                if (w_byte == r_start_byte) begin
                    n_count  = CNT_CRC_LO;
                    n_target = 9'd0;
                    n_rcrc   = 16'd0;
                    n_crc    = CRC_INIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_max_frame  <= MAX_FRAME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_BYTE: r_start_byte <= i_cfg_data[7:0];
                CFG_MAX_FRAME:  r_max_frame  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_count  <= 9'd0;
            r_target <= 9'd0;
            r_rcrc   <= 16'd0;
            r_crc    <= CRC_INIT;
            r_type   <= 8'd0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_target <= n_target;
            r_rcrc   <= n_rcrc;
            r_crc    <= n_crc;
            r_type   <= n_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready) begin
            r_out_valid <= w_fire && n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_res) begin
            r_out_byte   <= n_res_byte;
            r_out_type   <= n_type;
            r_out_last   <= n_res_last;
            r_out_has    <= n_res_has;
            r_out_status <= n_res_status;
        end
    end

    assign i_rx.ready         = w_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.packet_type  = r_out_type;
    assign o_res.is_last      = r_out_last;
    assign o_res.has_byte     = r_out_has;
    assign o_res.frame_status = r_out_status;

endmodule
